// File: src/jump_trampoline_encoder_defines.svh
// Assertion macros shared by the jump trampoline encoder RTL.
`ifndef JUMP_TRAMPOLINE_ENCODER_DEFINES_SVH
`define JUMP_TRAMPOLINE_ENCODER_DEFINES_SVH

// Same-cycle implication, disabled while reset is high.
`define JTE_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define JTE_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: src/jte_pkg.sv
// Shared constants and types for the jump trampoline encoder.
package jte_pkg;

   localparam int MAX_LEN     = 12;
   localparam int QUEUE_DEPTH = 2;

   localparam logic [7:0] OP_JMP_SHORT = 8'hEB;
   localparam logic [7:0] OP_JMP_NEAR  = 8'hE9;
   localparam logic [7:0] OP_MOV_EAX   = 8'hB8;
   localparam logic [7:0] OP_REX_W     = 8'h48;
   localparam logic [7:0] OP_GRP5      = 8'hFF;
   localparam logic [7:0] MODRM_JMPRAX = 8'hE0;

   localparam logic [3:0] LEN_SHORT = 4'd2;
   localparam logic [3:0] LEN_NEAR  = 4'd5;
   localparam logic [3:0] LEN_ABS32 = 4'd7;
   localparam logic [3:0] LEN_ABS64 = 4'd12;

   // Ranges on delta = target - source that pass the conservative width tests
   // for rel8 (delta - 2) and rel32 (delta - 5).
   localparam logic signed [63:0] SHORT_MIN = -64'sd125;
   localparam logic signed [63:0] SHORT_MAX = 64'sd128;
   localparam logic signed [63:0] NEAR_MIN  = -64'sd2147483642;
   localparam logic signed [63:0] NEAR_MAX  = 64'sd2147483651;

   typedef logic [MAX_LEN-1:0][7:0] code_type;

   typedef struct packed {
      code_type   code;
      logic [3:0] len;
      logic       failed;
   } entry_type;

endpackage

// File: src/jte_req_if.sv
// Input channel: source/target addresses and available room.
interface jte_req_if;
   logic        valid;
   logic        ready;
   logic [63:0] source_address;
   logic [63:0] target_address;
   logic [15:0] room;

   modport source (output valid, output source_address, output target_address,
                   output room, input ready);
   modport sink   (input valid, input source_address, input target_address,
                   input room, output ready);
endinterface

// File: src/jte_rsp_if.sv
// Result channel: one encoded byte per transaction.
interface jte_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] code_byte;
   logic [3:0] byte_index;
   logic       failed;
   logic       last;

   modport source (output valid, output code_byte, output byte_index,
                   output failed, output last, input ready);
   modport sink   (input valid, input code_byte, input byte_index,
                   input failed, input last, output ready);
endinterface

// File: src/jte_front.sv
// Front end: takes a request, picks the jump form and builds its bytes.
module jte_front (
   input  logic               clock,
   input  logic               reset,
   jte_req_if.sink            req_chan,
   output logic               push_valid,
   input  logic               push_ready,
   output jte_pkg::entry_type push_data
);
   import jte_pkg::*;

   logic        a_valid_ff, a_valid_in;
   logic [63:0] a_delta_ff, a_delta_in;
   logic [63:0] a_target_ff, a_target_in;
   logic [15:0] a_room_ff, a_room_in;
   logic        a_load;

   logic        short_ok, near_ok, abs32_ok;
   logic [7:0]  rel8;
   logic [31:0] rel32;
   code_type    code;
   logic [3:0]  len;

   assign a_load         = !a_valid_ff || push_ready;
   assign req_chan.ready = a_load;

   always_comb begin
      a_valid_in  = a_valid_ff;
      a_delta_in  = a_delta_ff;
      a_target_in = a_target_ff;
      a_room_in   = a_room_ff;
      if (a_load) begin
         a_valid_in  = req_chan.valid;
         a_delta_in  = req_chan.target_address - req_chan.source_address;
         a_target_in = req_chan.target_address;
         a_room_in   = req_chan.room;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
      end else begin
         a_valid_ff <= a_valid_in;
      end
      a_delta_ff  <= a_delta_in;
      a_target_ff <= a_target_in;
      a_room_ff   <= a_room_in;
   end

   assign short_ok = ($signed(a_delta_ff) >= SHORT_MIN) && ($signed(a_delta_ff) <= SHORT_MAX);
   assign near_ok  = ($signed(a_delta_ff) >= NEAR_MIN) && ($signed(a_delta_ff) <= NEAR_MAX);
   assign abs32_ok = (a_target_ff[63:32] == 32'd0);
   assign rel8     = a_delta_ff[7:0] - 8'd2;
   assign rel32    = a_delta_ff[31:0] - 32'd5;

   always_comb begin
      code = '0;
      len  = LEN_ABS64;
      if (short_ok) begin
         len     = LEN_SHORT;
         code[0] = OP_JMP_SHORT;
         code[1] = rel8;
      end else if (near_ok) begin
         len     = LEN_NEAR;
         code[0] = OP_JMP_NEAR;
         for (int i = 0; i < 4; i++) begin
            code[1 + i] = rel32[8*i +: 8];
         end
      end else if (abs32_ok) begin
         len     = LEN_ABS32;
         code[0] = OP_MOV_EAX;
         for (int i = 0; i < 4; i++) begin
            code[1 + i] = a_target_ff[8*i +: 8];
         end
         code[5] = OP_GRP5;
         code[6] = MODRM_JMPRAX;
      end else begin
         code[0] = OP_REX_W;
         code[1] = OP_MOV_EAX;
         for (int i = 0; i < 8; i++) begin
            code[2 + i] = a_target_ff[8*i +: 8];
         end
         code[10] = OP_GRP5;
         code[11] = MODRM_JMPRAX;
      end
   end

   assign push_valid       = a_valid_ff;
   assign push_data.code   = code;
   assign push_data.len    = len;
   // no fallback to a longer form when room is short
   assign push_data.failed = (a_room_ff < {12'd0, len});

endmodule

// File: src/jte_fifo.sv
// Short queue of encoded jumps between front and back end.
module jte_fifo #(
   parameter int Depth = jte_pkg::QUEUE_DEPTH
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               push_valid,
   output logic               push_ready,
   input  jte_pkg::entry_type push_data,
   output logic               pop_valid,
   input  logic               pop_ready,
   output jte_pkg::entry_type pop_data
);
   import jte_pkg::*;

   localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
   localparam int CntW = $clog2(Depth + 1);
   localparam logic [PtrW-1:0] PtrLast = PtrW'(Depth - 1);
   localparam logic [CntW-1:0] CntFull = CntW'(Depth);

   entry_type       slot_ff [Depth];
   logic [PtrW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PtrW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CntW-1:0] count_ff, count_in;
   logic            do_push, do_pop;

   assign push_ready = (count_ff != CntFull);
   assign pop_valid  = (count_ff != '0);
   assign pop_data   = slot_ff[rd_ptr_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop_valid && pop_ready;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PtrLast) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PtrLast) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

// File: src/jte_back.sv
// Back end: streams the bytes of the head entry, one per transaction.
module jte_back (
   input  logic               clock,
   input  logic               reset,
   input  logic               entry_valid,
   output logic               entry_ready,
   input  jte_pkg::entry_type entry,
   jte_rsp_if.source          rsp_chan
);
   import jte_pkg::*;

   logic [3:0] idx_ff, idx_in;
   logic       valid_ff, valid_in;
   logic [7:0] byte_ff, byte_in;
   logic [3:0] index_ff, index_in;
   logic       failed_ff, failed_in;
   logic       last_ff, last_in;
   logic       out_load, fire, is_last;

   assign out_load    = !valid_ff || rsp_chan.ready;
   assign fire        = entry_valid && out_load;
   assign is_last     = entry.failed || (idx_ff == entry.len - 4'd1);
   assign entry_ready = fire && is_last;

   always_comb begin
      idx_in    = idx_ff;
      valid_in  = valid_ff;
      byte_in   = byte_ff;
      index_in  = index_ff;
      failed_in = failed_ff;
      last_in   = last_ff;
      if (out_load) begin
         valid_in  = entry_valid;
         byte_in   = entry.failed ? 8'd0 : entry.code[idx_ff];
         index_in  = entry.failed ? 4'd0 : idx_ff;
         failed_in = entry.failed;
         last_in   = is_last;
      end
      if (fire) begin
         idx_in = is_last ? 4'd0 : idx_ff + 4'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff   <= '0;
         valid_ff <= 1'b0;
      end else begin
         idx_ff   <= idx_in;
         valid_ff <= valid_in;
      end
      byte_ff   <= byte_in;
      index_ff  <= index_in;
      failed_ff <= failed_in;
      last_ff   <= last_in;
   end

   assign rsp_chan.valid      = valid_ff;
   assign rsp_chan.code_byte  = byte_ff;
   assign rsp_chan.byte_index = index_ff;
   assign rsp_chan.failed     = failed_ff;
   assign rsp_chan.last       = last_ff;

endmodule

// File: src/jump_trampoline_encoder.sv
// Each request (source, target, room) yields the shortest x86-64 jump from source to
// target, streamed one byte per response transaction with its index: EB rel8 (2 bytes),
// E9 rel32 (5), B8 imm32 FF E0 (7) or 48 B8 imm64 FF E0 (12), immediates little-endian.
// If room is below the chosen length, one response with failed set and zero byte/index
// is sent instead. A request yields one response transaction per byte it has (1, 2, 5,
// 7 or 12), all through the single byte-wide output register. A request passes the
// front-end register, the queue and the output register in turn; the front end keeps
// accepting while the queue between front and back end has room.
module jump_trampoline_encoder #(
   parameter int QueueDepth = jte_pkg::QUEUE_DEPTH
) (
   input  logic      clock,
   input  logic      reset,
   jte_req_if.sink   req_chan,
   jte_rsp_if.source rsp_chan
);
   import jte_pkg::*;
   `include "jump_trampoline_encoder_defines.svh"

   logic      push_valid, push_ready;
   logic      pop_valid, pop_ready;
   entry_type push_data, pop_data;

   jte_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_chan   (req_chan),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_data  (push_data)
   );

   jte_fifo #(
      .Depth (QueueDepth)
   ) u_fifo (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_data  (push_data),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_data   (pop_data)
   );

   jte_back u_back (
      .clock       (clock),
      .reset       (reset),
      .entry_valid (pop_valid),
      .entry_ready (pop_ready),
      .entry       (pop_data),
      .rsp_chan    (rsp_chan)
   );

   // a failure transaction stands alone
   `JTE_ASSERT_SAME(a_fail_alone, clock, reset, rsp_chan.valid && rsp_chan.failed, rsp_chan.last && (rsp_chan.code_byte == 8'd0) && (rsp_chan.byte_index == 4'd0), "failure transaction is not a lone zero byte")

   // final byte index matches one of the four encodings
   `JTE_ASSERT_SAME(a_last_len, clock, reset, rsp_chan.valid && rsp_chan.last && !rsp_chan.failed, (rsp_chan.byte_index == 4'd1) || (rsp_chan.byte_index == 4'd4) || (rsp_chan.byte_index == 4'd6) || (rsp_chan.byte_index == 4'd11), "sequence ends at an impossible length")

   // bytes of one sequence go out back to back, in order
   `JTE_ASSERT_NEXT(a_contiguous, clock, reset, rsp_chan.valid && rsp_chan.ready && !rsp_chan.last, rsp_chan.valid && (rsp_chan.byte_index == $past(rsp_chan.byte_index) + 4'd1), "gap or skip inside a sequence")

endmodule

// File: bench/tb_jump_trampoline_encoder.sv
// Self-checking testbench for the jump trampoline encoder: directed table plus random requests.
module tb_jump_trampoline_encoder;
   import jte_pkg::*;

   localparam int PREDICT = -1;   // row expectation comes from the predictor
   localparam int NO_ROOM = 0;    // row expects the single failure byte

   typedef logic [0:MAX_LEN-1][7:0] seq_bytes_type;   // byte 0 is the leftmost

   typedef struct packed {
      logic [7:0] code_byte;
      logic [3:0] byte_index;
      logic       failed;
      logic       last;
   } code_beat_type;

   typedef struct {
      logic [63:0]   src;
      logic [63:0]   dst;
      logic [15:0]   room;
      int            len;
      seq_bytes_type code;
   } jump_vector_type;

   typedef enum int {FORM_SHORT, FORM_NEAR, FORM_ABS32, FORM_ABS64} jump_form_type;

   logic clock = 1'b0;
   logic reset;
   bit   steady = 1'b0;

   code_beat_type   pending_bytes[$];
   jump_vector_type jump_vectors[$];
   int              form_hits[4];
   int              room_failures = 0;
   int              requests_sent = 0;
   int              bytes_checked = 0;
   int              errors = 0;

   jte_req_if req_bus ();
   jte_rsp_if rsp_bus ();

   jump_trampoline_encoder uut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_bus),
      .rsp_chan (rsp_bus)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   initial begin
      #2_000_000;
      $display("Timeout with %0d bytes still outstanding", pending_bytes.size());
      $display("Some tests failed");
      $finish;
   end

   // Magnitude test on a signed displacement: |v| for negatives, v + 1 otherwise,
   // must stay below 2^(bits-1). Rejects the most negative value on purpose.
   function automatic bit passes_width(logic [63:0] v, int unsigned bits);
      logic [63:0] mag;
      mag = v[63] ? (64'd0 - v) : (v + 64'd1);
      return mag < (64'd1 << (bits - 1));
   endfunction

   function automatic void push_sequence(int len, seq_bytes_type code);
      code_beat_type beat;
      if (len == NO_ROOM) begin
         beat = '{code_byte: 8'h00, byte_index: 4'd0, failed: 1'b1, last: 1'b1};
         pending_bytes.push_back(beat);
      end else begin
         for (int k = 0; k < len; k++) begin
            beat = '{code_byte: code[k], byte_index: 4'(k), failed: 1'b0,
                     last: (k == len - 1)};
            pending_bytes.push_back(beat);
         end
      end
   endfunction

   function automatic void predict_jump(logic [63:0] src, logic [63:0] dst,
                                        logic [15:0] room);
      logic [63:0]   delta;
      logic [63:0]   disp;
      seq_bytes_type code;
      int            len;
      jump_form_type form;
      delta = dst - src;
      code  = '0;
      if (passes_width(delta - 64'd2, 8)) begin
         disp    = delta - 64'd2;
         form    = FORM_SHORT;
         len     = int'(LEN_SHORT);
         code[0] = OP_JMP_SHORT;
         code[1] = disp[7:0];
      end else if (passes_width(delta - 64'd5, 32)) begin
         disp    = delta - 64'd5;
         form    = FORM_NEAR;
         len     = int'(LEN_NEAR);
         code[0] = OP_JMP_NEAR;
         for (int k = 0; k < 4; k++) code[1 + k] = disp[8*k +: 8];
      end else if (dst[63:32] == 32'h0) begin
         form    = FORM_ABS32;
         len     = int'(LEN_ABS32);
         code[0] = OP_MOV_EAX;
         for (int k = 0; k < 4; k++) code[1 + k] = dst[8*k +: 8];
         code[5] = OP_GRP5;
         code[6] = MODRM_JMPRAX;
      end else begin
         form     = FORM_ABS64;
         len      = int'(LEN_ABS64);
         code[0]  = OP_REX_W;
         code[1]  = OP_MOV_EAX;
         for (int k = 0; k < 8; k++) code[2 + k] = dst[8*k +: 8];
         code[10] = OP_GRP5;
         code[11] = MODRM_JMPRAX;
      end
      form_hits[form]++;
      if (int'(room) < len) begin
         room_failures++;
         push_sequence(NO_ROOM, code);
      end else begin
         push_sequence(len, code);
      end
   endfunction

   function automatic void add_vec(logic [63:0] src, logic [63:0] dst, logic [15:0] room,
                                   int len = PREDICT, seq_bytes_type code = '0);
      jump_vector_type v;
      v = '{src: src, dst: dst, room: room, len: len, code: code};
      jump_vectors.push_back(v);
   endfunction

   // Valid stays high after a transaction; the next call either replaces the payload
   // or drops valid for a gap.
   task automatic send_request(logic [63:0] src, logic [63:0] dst, logic [15:0] room,
                               int len, seq_bytes_type code);
      @(negedge clock);
      if (!steady && $urandom_range(0, 99) < 10) begin
         req_bus.valid <= 1'b0;
         repeat ($urandom_range(1, 3)) @(negedge clock);
      end
      req_bus.valid          <= 1'b1;
      req_bus.source_address <= src;
      req_bus.target_address <= dst;
      req_bus.room           <= room;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      requests_sent++;
      if (len == PREDICT) predict_jump(src, dst, room);
      else push_sequence(len, code);
   endtask

   task automatic random_request();
      logic [63:0] src;
      logic [63:0] dst;
      logic [31:0] r32;
      logic [15:0] room;
      int          pick;
      pick = $urandom_range(0, 9);
      src  = {$urandom, $urandom};
      case (pick) inside
         [0:2]: begin
            // displacement straddles both ends of the rel8 window
            dst = src + 64'd2 + 64'($urandom_range(0, 260)) - 64'd130;
         end
         [3:4]: begin
            r32 = $urandom;
            if ($urandom_range(0, 2) == 0) begin
               r32 = $urandom_range(0, 1) ? 32'h7FFF_FFFF - 32'($urandom_range(0, 3))
                                          : 32'h8000_0000 + 32'($urandom_range(0, 3));
            end
            dst = src + 64'd5 + {{32{r32[31]}}, r32};
         end
         [5:6]: begin
            // low target, source far enough above that rel32 cannot reach
            dst        = {32'h0, $urandom};
            src[63:32] = $urandom_range(4, 32'h7FFF_FFFF);
         end
         default: begin
            dst = {$urandom, $urandom};
         end
      endcase
      if (pick == 9) begin
         room = 16'($urandom);
      end else begin
         case ($urandom_range(0, 7)) inside
            [0:3]:   room = 16'($urandom_range(0, 13));
            [4:6]:   room = 16'($urandom_range(12, 200));
            default: room = 16'hFFFF;
         endcase
      end
      send_request(src, dst, room, PREDICT, '0);
   endtask

   function automatic void check_field(string what, logic [7:0] want, logic [7:0] got);
      if (got !== want) begin
         errors++;
         $display("%0t: %s mismatch, expected %h, got %h", $time, what, want, got);
      end
   endfunction

   always @(negedge clock) begin
      rsp_bus.ready <= !reset && (steady || $urandom_range(0, 99) >= 10);
   end

   always @(posedge clock) begin
      code_beat_type want;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         if (pending_bytes.size() == 0) begin
            errors++;
            $display("%0t: unexpected transaction, expected none, got byte %h idx %0d "
                     , $time, rsp_bus.code_byte, rsp_bus.byte_index,
                     "failed %b last %b", rsp_bus.failed, rsp_bus.last);
         end else begin
            want = pending_bytes.pop_front();
            check_field("code_byte", want.code_byte, rsp_bus.code_byte);
            check_field("byte_index", 8'(want.byte_index), 8'(rsp_bus.byte_index));
            check_field("failed", 8'(want.failed), 8'(rsp_bus.failed));
            check_field("last", 8'(want.last), 8'(rsp_bus.last));
            bytes_checked++;
         end
      end
   end

   initial begin
      reset                  = 1'b1;
      req_bus.valid          = 1'b0;
      req_bus.source_address = 64'h0;
      req_bus.target_address = 64'h0;
      req_bus.room           = 16'h0;
      rsp_bus.ready          = 1'b0;

      // short jump edges: displacement 0, +126, -127, and one past each
      add_vec(64'h1000, 64'h1002, 16'd2, int'(LEN_SHORT), {OP_JMP_SHORT, 8'h00, 80'h0});
      add_vec(64'h1000, 64'h1080, 16'd2, int'(LEN_SHORT), {OP_JMP_SHORT, 8'h7E, 80'h0});
      add_vec(64'h1000, 64'h1081, 16'd5);
      add_vec(64'h1000, 64'h0F83, 16'hFFFF, int'(LEN_SHORT), {OP_JMP_SHORT, 8'h81, 80'h0});
      add_vec(64'h1000, 64'h0F82, 16'd5);
      add_vec(64'h7FFF_FFFF_FFFF_FFFF, 64'h7FFF_FFFF_FFFF_FFFF, 16'd2,
              int'(LEN_SHORT), {OP_JMP_SHORT, 8'hFE, 80'h0});
      // address extremes wrap around to short jumps
      add_vec(64'h0, 64'hFFFF_FFFF_FFFF_FFFF, 16'd2);
      add_vec(64'hFFFF_FFFF_FFFF_FFFF, 64'h0, 16'd2);
      // rel32 edges and the first values that fall back to absolute forms
      add_vec(64'h0, 64'h8000_0003, 16'd5);
      add_vec(64'h0, 64'h8000_0004, 16'd7);
      add_vec(64'h8000_0000, 64'h6, 16'd5);
      add_vec(64'h8000_0000, 64'h5, 16'd7);
      add_vec(64'h1000, 64'h2000, 16'd5);
      add_vec(64'hFFFF_FFFF_0000_0000, 64'hFFFF_FFFF, 16'd7);
      add_vec(64'h1234_5678_9ABC_DEF0, 64'h0BAD_F00D, 16'hFFFF);
      add_vec(64'h0, 64'h8000_0000_0000_0000, 16'd12, int'(LEN_ABS64),
              {OP_REX_W, OP_MOV_EAX, 56'h0, 8'h80, OP_GRP5, MODRM_JMPRAX});
      add_vec(64'h2_0000_0000, 64'h1_0000_0000, 16'd12);
      add_vec(64'h1000, 64'hFEDC_BA98_7654_3210, 16'hFFFF);
      // room one short of each form, and no room at all
      add_vec(64'h1000, 64'h1002, 16'd0, NO_ROOM);
      add_vec(64'h1000, 64'h1002, 16'd1, NO_ROOM);
      add_vec(64'h1000, 64'h2000, 16'd4, NO_ROOM);
      add_vec(64'h0, 64'h8000_0004, 16'd6, NO_ROOM);
      add_vec(64'h0, 64'h8000_0000_0000_0000, 16'd11, NO_ROOM);

      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      foreach (jump_vectors[i]) begin
         send_request(jump_vectors[i].src, jump_vectors[i].dst, jump_vectors[i].room,
                      jump_vectors[i].len, jump_vectors[i].code);
      end

      for (int i = 0; i < 258; i++) begin
         steady = (i >= 80 && i < 140);
         if (i == 180) begin
            // let the encoder drain completely before resuming
            @(negedge clock);
            req_bus.valid <= 1'b0;
            while (pending_bytes.size() != 0) @(posedge clock);
         end
         random_request();
      end
      steady = 1'b0;

      @(negedge clock);
      req_bus.valid <= 1'b0;
      while (pending_bytes.size() != 0) @(posedge clock);
      repeat (30) @(posedge clock);

      $display("Sent %0d requests (%0d from the table), compared %0d code bytes",
               requests_sent, jump_vectors.size(), bytes_checked);
      $display("Predicted forms: %0d short, %0d near, %0d abs32, %0d abs64; %0d room failures",
               form_hits[FORM_SHORT], form_hits[FORM_NEAR], form_hits[FORM_ABS32],
               form_hits[FORM_ABS64], room_failures);
      if (errors == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule

// File: sim.f
+incdir+src
src/jte_pkg.sv
src/jte_req_if.sv
src/jte_rsp_if.sv
src/jte_front.sv
src/jte_fifo.sv
src/jte_back.sv
src/jump_trampoline_encoder.sv
bench/tb_jump_trampoline_encoder.sv
